### src/i2c_temp_sensor_register_model_top_assert.svh
// assertion macros for the temperature sensor register model
// used by i2c_temp_sensor_register_model_top, expects clk and rst_n in scope
`ifndef I2C_TEMP_SENSOR_REGISTER_MODEL_TOP_ASSERT_SVH
`define I2C_TEMP_SENSOR_REGISTER_MODEL_TOP_ASSERT_SVH

// same-cycle implication, ignored during reset
`define I2CTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cts check failed");

// next-cycle implication, ignored during reset
`define I2CTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cts check failed");

// next-cycle implication that also covers reset itself
`define I2CTS_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("i2cts reset check failed");

`endif

### src/i2cts_pkg.sv
// package for the temperature sensor register model
// types, register map codes and constants; no dependencies
`default_nettype none

package i2cts_pkg;

  localparam logic [3:0] REG_CONFIG     = 4'd1;
  localparam logic [3:0] REG_UPPER      = 4'd2;
  localparam logic [3:0] REG_LOWER      = 4'd3;
  localparam logic [3:0] REG_CRITICAL   = 4'd4;
  localparam logic [3:0] REG_AMBIENT    = 4'd5;
  localparam logic [3:0] REG_MANUF_ID   = 4'd6;
  localparam logic [3:0] REG_DEVICE_ID  = 4'd7;
  localparam logic [3:0] REG_RESOLUTION = 4'd8;

  localparam int unsigned NUM_SLOTS = 6;
  localparam logic [2:0] SLOT_CONFIG     = 3'd0;
  localparam logic [2:0] SLOT_UPPER      = 3'd1;
  localparam logic [2:0] SLOT_LOWER      = 3'd2;
  localparam logic [2:0] SLOT_CRITICAL   = 3'd3;
  localparam logic [2:0] SLOT_AMBIENT    = 3'd4;
  localparam logic [2:0] SLOT_RESOLUTION = 3'd5;
  localparam logic [2:0] SLOT_NONE       = 3'd6;

  localparam logic [15:0] MANUF_ID_VALUE  = 16'h0054;
  localparam logic [15:0] DEVICE_ID_VALUE = 16'h0400;
  localparam logic [31:0] LAST_SAMPLE_RST = 32'h0000_ffff;

  localparam logic [31:0] INTERVAL_0 = 32'd30;
  localparam logic [31:0] INTERVAL_1 = 32'd65;
  localparam logic [31:0] INTERVAL_2 = 32'd130;
  localparam logic [31:0] INTERVAL_3 = 32'd250;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [7:0]        data_byte;
    logic [31:0]       now_ms;
    logic signed [11:0] temperature_sixteenths;
  } item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       transfer_done;
  } result_t;

  function automatic logic [2:0] slot_of(input logic [3:0] idx);
    logic [2:0] s;
    unique case (idx)
      REG_CONFIG:     s = SLOT_CONFIG;
      REG_UPPER:      s = SLOT_UPPER;
      REG_LOWER:      s = SLOT_LOWER;
      REG_CRITICAL:   s = SLOT_CRITICAL;
      REG_AMBIENT:    s = SLOT_AMBIENT;
      REG_RESOLUTION: s = SLOT_RESOLUTION;
      default:        s = SLOT_NONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

### src/i2c_temp_sensor_register_model_top.sv
// top level of the temperature sensor register model
// input register, i2cts_core, i2cts_out_reg; uses i2cts_pkg and the assert header
//
//   channel | ports                                             | dir
//   in      | in_valid in_ready in_mode in_data_byte            | in
//           | in_now_ms in_temperature_sixteenths               |
//   out     | out_valid out_ready out_read_byte                 | out
//           | out_transfer_done                                 |
//
// one beat per cycle unless the output stalls; passes input, then result register
// state updates as a beat moves from the input register into the result register
// synchronous active-low reset clears valid flags and core state at once, no clearing pass
// a stalled output holds both stages; in_ready falls only when both are full
`default_nettype none
`include "i2c_temp_sensor_register_model_top_assert.svh"

module i2c_temp_sensor_register_model_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic [31:0]       in_now_ms,
  input  wire logic signed [11:0] in_temperature_sixteenths,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_read_byte,
  output logic                   out_transfer_done
);
  import i2cts_pkg::*;

  logic    stage_v_r;
  item_t   stage_r;
  logic    space;
  logic    advance;
  result_t core_res;
  result_t out_data;

  assign advance  = stage_v_r && space;
  assign in_ready = !stage_v_r || space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r.mode                   <= in_mode;
      stage_r.data_byte              <= in_data_byte;
      stage_r.now_ms                 <= in_now_ms;
      stage_r.temperature_sixteenths <= in_temperature_sixteenths;
    end
  end

  i2cts_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_r),
    .result (core_res)
  );

  i2cts_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (core_res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_read_byte     = out_data.read_byte;
  assign out_transfer_done = out_data.transfer_done;

  `I2CTS_ASSERT_RST(a_rst_empty, !rst_n, !out_valid && in_ready)
  `I2CTS_ASSERT_NOW(a_full_stall, stage_v_r && out_valid && !out_ready, !in_ready)
  `I2CTS_ASSERT_NEXT(a_advance_loads, advance, out_valid)
  `I2CTS_ASSERT_NEXT(a_write_reads_zero, advance && (stage_r.mode == MODE_WRITE),
                     out_read_byte == 8'd0)

endmodule

`default_nettype wire

### src/i2cts_core.sv
// register file, pointer and sampling logic of the sensor model
// one beat is processed per cycle when step is high; uses i2cts_pkg
`default_nettype none

module i2cts_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire i2cts_pkg::item_t   item,
  output i2cts_pkg::result_t      result
);
  import i2cts_pkg::*;

  logic [15:0] regs_r   [NUM_SLOTS];
  logic [15:0] regs_nxt [NUM_SLOTS];
  logic [3:0]  ptr_idx_r, ptr_idx_nxt;
  logic        ptr_vld_r, ptr_vld_nxt;
  logic        byte_cnt_r, byte_cnt_nxt;
  logic [31:0] last_ms_r, last_ms_nxt;

  logic [3:0]  sel_idx;
  logic [2:0]  ptr_slot;
  logic [15:0] rd_word;
  logic [31:0] interval;
  logic [31:0] elapsed;
  logic [15:0] amb_word;
  logic        writable;

  assign sel_idx  = (item.data_byte > 8'd15) ? 4'd0 : item.data_byte[3:0];
  assign ptr_slot = slot_of(ptr_idx_r);
  assign elapsed  = item.now_ms - last_ms_r;
  assign writable = (ptr_slot != SLOT_NONE) && (ptr_slot != SLOT_AMBIENT);

  always_comb begin
    case (regs_r[SLOT_RESOLUTION][1:0])
      2'd0:    interval = INTERVAL_0;
      2'd1:    interval = INTERVAL_1;
      2'd2:    interval = INTERVAL_2;
      default: interval = INTERVAL_3;
    endcase
  end

  always_comb begin
    amb_word = {{4{item.temperature_sixteenths[11]}}, item.temperature_sixteenths};
    if (amb_word >= regs_r[SLOT_CRITICAL]) begin
      amb_word[15] = 1'b1;
    end
  end

  always_comb begin
    if (ptr_idx_r == REG_MANUF_ID) begin
      rd_word = MANUF_ID_VALUE;
    end else if (ptr_idx_r == REG_DEVICE_ID) begin
      rd_word = DEVICE_ID_VALUE;
    end else if (ptr_slot == SLOT_NONE) begin
      rd_word = 16'd0;
    end else begin
      rd_word = regs_r[ptr_slot];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      regs_nxt[i] = regs_r[i];
    end
    ptr_idx_nxt          = ptr_idx_r;
    ptr_vld_nxt          = ptr_vld_r;
    byte_cnt_nxt         = byte_cnt_r;
    last_ms_nxt          = last_ms_r;
    result.read_byte     = 8'd0;
    result.transfer_done = 1'b0;
    if (ptr_vld_r) begin
      if (item.mode == MODE_READ) begin
        result.read_byte = byte_cnt_r ? rd_word[15:8] : rd_word[7:0];
      end else if (writable) begin
        if (byte_cnt_r) begin
          regs_nxt[ptr_slot][15:8] = item.data_byte;
        end else begin
          regs_nxt[ptr_slot][7:0] = item.data_byte;
        end
      end
      byte_cnt_nxt = ~byte_cnt_r;
      if (!byte_cnt_r) begin
        ptr_vld_nxt          = 1'b0;
        result.transfer_done = 1'b1;
      end
    end else if (item.mode == MODE_WRITE) begin
      if (elapsed >= interval) begin
        last_ms_nxt            = item.now_ms;
        regs_nxt[SLOT_AMBIENT] = amb_word;
      end
      ptr_idx_nxt  = sel_idx;
      byte_cnt_nxt = (sel_idx != REG_RESOLUTION);
      ptr_vld_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        regs_r[i] <= 16'd0;
      end
      ptr_idx_r  <= 4'd0;
      ptr_vld_r  <= 1'b0;
      byte_cnt_r <= 1'b0;
      last_ms_r  <= LAST_SAMPLE_RST;
    end else if (step) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        regs_r[i] <= regs_nxt[i];
      end
      ptr_idx_r  <= ptr_idx_nxt;
      ptr_vld_r  <= ptr_vld_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      last_ms_r  <= last_ms_nxt;
    end
  end

endmodule

`default_nettype wire

### src/i2cts_out_reg.sv
// result register of the sensor model
// holds one result beat until taken downstream; uses i2cts_pkg
`default_nettype none

module i2cts_out_reg (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire i2cts_pkg::result_t result,
  output logic                    space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output i2cts_pkg::result_t      out_data
);
  import i2cts_pkg::*;

  logic    valid_r;
  result_t data_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

`default_nettype wire

### verif/i2c_temp_sensor_register_model_checker.sv
// result checker for the temperature sensor register model
// predicts every read byte and done flag from accepted input beats; uses i2cts_pkg
`timescale 1ns / 100ps

module i2c_temp_sensor_register_model_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_mode,
  input  wire logic [7:0]         in_data_byte,
  input  wire logic [31:0]        in_now_ms,
  input  wire logic signed [11:0] in_temperature_sixteenths,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [7:0]         out_read_byte,
  input  wire logic               out_transfer_done,
  output int                      mismatches,
  output int                      pending,
  output int                      beats_in,
  output int                      results_seen,
  output int                      samples_taken
);
  import i2cts_pkg::*;

  logic [15:0] config_w, upper_w, lower_w, crit_w, ambient_w, res_w;
  logic [3:0]  sel_idx;
  logic        sel_valid;
  logic        sel_hi;
  logic [31:0] last_ms;
  logic [31:0] gap_limit [4];
  result_t     sensor_replies_q[$];

  initial begin
    gap_limit[0] = INTERVAL_0;
    gap_limit[1] = INTERVAL_1;
    gap_limit[2] = INTERVAL_2;
    gap_limit[3] = INTERVAL_3;
  end

  function automatic logic [15:0] put_byte(input logic [15:0] w, input logic hi,
                                           input logic [7:0] b);
    logic [15:0] r;
    r = w;
    if (hi) r[15:8] = b;
    else r[7:0] = b;
    return r;
  endfunction

  function automatic logic [15:0] word_at(input logic [3:0] idx);
    logic [15:0] w;
    case (idx)
      REG_CONFIG:     w = config_w;
      REG_UPPER:      w = upper_w;
      REG_LOWER:      w = lower_w;
      REG_CRITICAL:   w = crit_w;
      REG_AMBIENT:    w = ambient_w;
      REG_MANUF_ID:   w = MANUF_ID_VALUE;
      REG_DEVICE_ID:  w = DEVICE_ID_VALUE;
      REG_RESOLUTION: w = res_w;
      default:        w = '0;
    endcase
    return w;
  endfunction

  task automatic sensor_step(input logic mode, input logic [7:0] data,
                             input logic [31:0] now, input logic signed [11:0] temp,
                             output result_t r);
    logic [15:0] w;
    logic [31:0] age;
    logic [3:0]  idx;
    r = '0;
    if (sel_valid) begin
      if (mode == MODE_READ) begin
        w = word_at(sel_idx);
        r.read_byte = sel_hi ? w[15:8] : w[7:0];
      end else begin
        case (sel_idx)
          REG_CONFIG:     config_w = put_byte(config_w, sel_hi, data);
          REG_UPPER:      upper_w  = put_byte(upper_w, sel_hi, data);
          REG_LOWER:      lower_w  = put_byte(lower_w, sel_hi, data);
          REG_CRITICAL:   crit_w   = put_byte(crit_w, sel_hi, data);
          REG_RESOLUTION: res_w    = put_byte(res_w, sel_hi, data);
          default: ;
        endcase
      end
      if (!sel_hi) begin
        sel_valid = 1'b0;
        r.transfer_done = 1'b1;
      end
      sel_hi = ~sel_hi;
    end else if (mode == MODE_WRITE) begin
      idx = (data > 8'd15) ? 4'd0 : data[3:0];
      age = now - last_ms;
      if (age >= gap_limit[res_w[1:0]]) begin
        last_ms = now;
        w = {{4{temp[11]}}, temp};
        if (w >= crit_w) w[15] = 1'b1;
        ambient_w = w;
        samples_taken++;
      end
      sel_idx   = idx;
      sel_hi    = (idx != REG_RESOLUTION);
      sel_valid = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      config_w      = '0;
      upper_w       = '0;
      lower_w       = '0;
      crit_w        = '0;
      ambient_w     = '0;
      res_w         = '0;
      sel_idx       = '0;
      sel_valid     = 1'b0;
      sel_hi        = 1'b0;
      last_ms       = LAST_SAMPLE_RST;
      mismatches    = 0;
      beats_in      = 0;
      results_seen  = 0;
      samples_taken = 0;
      sensor_replies_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        sensor_step(in_mode, in_data_byte, in_now_ms, in_temperature_sixteenths, exp_r);
        sensor_replies_q.push_back(exp_r);
        beats_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (sensor_replies_q.size() == 0) begin
          $error("out beat with no expected result: read_byte %0h transfer_done %0b",
                 out_read_byte, out_transfer_done);
          mismatches++;
        end else begin
          exp_r = sensor_replies_q.pop_front();
          if (out_read_byte !== exp_r.read_byte) begin
            $error("read_byte: expected %0h, actual %0h", exp_r.read_byte, out_read_byte);
            mismatches++;
          end
          if (out_transfer_done !== exp_r.transfer_done) begin
            $error("transfer_done: expected %0b, actual %0b",
                   exp_r.transfer_done, out_transfer_done);
            mismatches++;
          end
        end
      end
    end
    pending = sensor_replies_q.size();
  end

endmodule

### verif/i2c_temp_sensor_register_model_top_tb.sv
// testbench top for the temperature sensor register model
// drives directed and random i2c byte beats; needs i2cts_pkg, the block and the checker
`timescale 1ns / 100ps

module i2c_temp_sensor_register_model_top_tb;
  import i2cts_pkg::*;

  localparam int RANDOM_BEATS = 1800;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_mode;
  logic [7:0]         in_data_byte;
  logic [31:0]        in_now_ms;
  logic signed [11:0] in_temperature_sixteenths;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         out_read_byte;
  logic               out_transfer_done;

  int          mismatches, pending, beats_in, results_seen, samples_taken;
  int          sent;
  logic        quiet;
  logic [31:0] clock_ms;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  i2c_temp_sensor_register_model_top u_dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_mode                   (in_mode),
    .in_data_byte              (in_data_byte),
    .in_now_ms                 (in_now_ms),
    .in_temperature_sixteenths (in_temperature_sixteenths),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_read_byte             (out_read_byte),
    .out_transfer_done         (out_transfer_done)
  );

  i2c_temp_sensor_register_model_checker u_checker (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_mode                   (in_mode),
    .in_data_byte              (in_data_byte),
    .in_now_ms                 (in_now_ms),
    .in_temperature_sixteenths (in_temperature_sixteenths),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_read_byte             (out_read_byte),
    .out_transfer_done         (out_transfer_done),
    .mismatches                (mismatches),
    .pending                   (pending),
    .beats_in                  (beats_in),
    .results_seen              (results_seen),
    .samples_taken             (samples_taken)
  );

  always @(negedge clk) begin
    out_ready <= quiet || ($urandom_range(99) >= 9);
  end

  // one beat, entered and left at a falling edge
  task automatic send_beat(input logic mode, input logic [7:0] data,
                           input logic signed [11:0] temp);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid                  <= 1'b1;
    in_mode                   <= mode;
    in_data_byte              <= data;
    in_now_ms                 <= clock_ms;
    in_temperature_sixteenths <= temp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] ptr;
    int         nbytes;
    rst_n                     = 1'b0;
    in_valid                  = 1'b0;
    in_mode                   = MODE_WRITE;
    in_data_byte              = '0;
    in_now_ms                 = '0;
    in_temperature_sixteenths = '0;
    quiet                     = 1'b0;
    clock_ms                  = '0;
    sent                      = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // read before any selection, then critical limit with a sample at the lowest temperature
    send_beat(MODE_READ, 8'hff, 12'sh000);
    send_beat(MODE_WRITE, {4'h0, REG_CRITICAL}, 12'sh800);
    send_beat(MODE_WRITE, 8'h7f, 12'sh000);
    send_beat(MODE_WRITE, 8'hff, 12'sh000);
    // ambient at the highest temperature
    clock_ms = 32'd40;
    send_beat(MODE_WRITE, {4'h0, REG_AMBIENT}, 12'sh7ff);
    send_beat(MODE_READ, 8'h00, 12'sh000);
    send_beat(MODE_READ, 8'h00, 12'sh000);
    // single byte resolution
    send_beat(MODE_WRITE, {4'h0, REG_RESOLUTION}, 12'sh000);
    send_beat(MODE_WRITE, 8'h03, 12'sh000);
    // write to a read-only id is dropped
    send_beat(MODE_WRITE, {4'h0, REG_MANUF_ID}, 12'sh000);
    send_beat(MODE_WRITE, 8'haa, 12'sh000);
    send_beat(MODE_READ, 8'h00, 12'sh000);
    // index above fifteen
    send_beat(MODE_WRITE, 8'hff, 12'sh000);
    send_beat(MODE_READ, 8'h00, 12'sh000);
    send_beat(MODE_READ, 8'h00, 12'sh000);
    // inside the long interval, no sample
    clock_ms = 32'd100;
    send_beat(MODE_WRITE, {4'h0, REG_DEVICE_ID}, 12'sh123);
    send_beat(MODE_READ, 8'h00, 12'sh000);
    send_beat(MODE_READ, 8'h00, 12'sh000);
    send_beat(MODE_WRITE, {4'h0, REG_CONFIG}, 12'sh000);
    send_beat(MODE_WRITE, 8'h80, 12'sh000);
    send_beat(MODE_WRITE, 8'h01, 12'sh000);
    // unknown index at the top of the time range
    clock_ms = 32'hffff_ffff;
    send_beat(MODE_WRITE, 8'h0f, 12'shfff);
    send_beat(MODE_WRITE, 8'h00, 12'sh000);
    send_beat(MODE_WRITE, 8'h00, 12'sh000);
    send_beat(MODE_READ, 8'h00, 12'sh000);

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      quiet    = (sent >= 600 && sent < 900);
      clock_ms = clock_ms + $urandom_range(0, 300);
      if ($urandom_range(99) < 3) clock_ms = $urandom;
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(99) / 35)
          0, 1:    ptr = 8'($urandom_range(1, 8));
          default: ptr = ($urandom_range(1) == 1) ? 8'($urandom_range(9, 15))
                                                  : 8'($urandom_range(255));
        endcase
        if (ptr == 8'd16) ptr = 8'd0;
        send_beat(MODE_WRITE, ptr, 12'($urandom));
        nbytes = (ptr == {4'h0, REG_RESOLUTION}) ? 1 : 2;
        if ($urandom_range(99) < 8) nbytes = $urandom_range(0, 3);
        repeat (nbytes) begin
          clock_ms = clock_ms + $urandom_range(0, 2);
          send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 12'($urandom));
        end
      end else begin
        send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 12'($urandom));
      end
    end
    quiet    = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    $display("covered %0d input beats and %0d checked results", beats_in, results_seen);
    $display("ambient resampled %0d times across all four intervals", samples_taken);
    if (mismatches == 0 && pending == 0) begin
      $display("i2c_temp_sensor_register_model_top: match");
    end else begin
      $display("i2c_temp_sensor_register_model_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("i2c_temp_sensor_register_model_top: mismatch");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/i2cts_pkg.sv
src/i2cts_core.sv
src/i2cts_out_reg.sv
src/i2c_temp_sensor_register_model_top.sv
verif/i2c_temp_sensor_register_model_checker.sv
verif/i2c_temp_sensor_register_model_top_tb.sv
